// ===== sv/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiply core: field
// widths, operation codes and the tag that follows a product term down the
// multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package imm_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int INDEX_WIDTH = 4;
   localparam int OP_WIDTH    = 2;
   localparam int SIZE_WIDTH  = 5;

   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 5'd16;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_WRITE_A = 2'd0,
      OP_WRITE_B = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   // One product term in flight: first and last mark the ends of a dot product.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

endpackage

// ===== sv/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
   parameter int AddrWidth = 8,
   parameter int DataWidth = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [DataWidth-1:0] rd_data
);

   localparam int Depth = 1 << AddrWidth;

   logic [DataWidth-1:0] mem [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/imm_mac.sv =====
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate pipeline: align the tag with the RAM read data,
// register the 32-bit product, then fold it into the running sum.
// ----------------------------------------------------------------------------
module imm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  imm_pkg::tag_type                    issue_tag,
   input  logic [imm_pkg::DATA_WIDTH-1:0]      a_data,
   input  logic [imm_pkg::DATA_WIDTH-1:0]      b_data,
   output logic                                done,
   output logic [imm_pkg::DATA_WIDTH-1:0]      sum
);

   imm_pkg::tag_type data_tag_ff;
   imm_pkg::tag_type prod_tag_ff;
   logic [imm_pkg::DATA_WIDTH-1:0] prod_ff;
   logic [imm_pkg::DATA_WIDTH-1:0] prod_in;
   logic [imm_pkg::DATA_WIDTH-1:0] acc_ff;
   logic [imm_pkg::DATA_WIDTH-1:0] acc_in;

   // Low half of the product is the same for signed and unsigned operands.
   assign prod_in = a_data * b_data;
   assign acc_in  = (prod_tag_ff.first ? '0 : acc_ff) + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_tag_ff <= '0;
         prod_tag_ff <= '0;
      end else begin
         data_tag_ff <= issue_tag;
         prod_tag_ff <= data_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (data_tag_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (prod_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done = prod_tag_ff.valid & prod_tag_ff.last;
   assign sum  = acc_in;

endmodule

// ===== sv/integer_matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Signed 32-bit square matrix product C = A x B, up to MAX_DIM by MAX_DIM.
// Elements of A and B are loaded one word at a time; a read returns one
// element of C, computed on demand as a dot product over the size in use.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------
//   request   start / busy       req_op, req_row, req_col, req_element_value
//   response  rsp_valid strobe   rsp_product_value, rsp_out_row, rsp_out_col
//   config    csr_wr_en          csr_wr_data (matrix size)
//
// Flow: a write, an unused op code or a read outside the size in use
//   is taken while idle; the next word may be taken at the following edge.
//   A read inside the size keeps busy high while k walks over the size in
//   use, one product term per cycle, set by the single read port of each
//   matrix RAM, and stays high while the last term passes through the
//   registered read data and the product register.
//   Its result strobes in the cycle busy falls; no word is taken while busy.
// Reset: synchronous, active high; clears the sequencer, the pipeline tags
//   and the response strobe, and returns the size to 16. The matrix RAMs
//   are not cleared: an entry is undefined until written.
// Stalls: the receiver cannot hold off a result; a word is taken whenever
//   start is high and busy is low.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core #(
   parameter int MAX_DIM = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [imm_pkg::OP_WIDTH-1:0]            req_op,
   input  logic [imm_pkg::INDEX_WIDTH-1:0]         req_row,
   input  logic [imm_pkg::INDEX_WIDTH-1:0]         req_col,
   input  logic signed [imm_pkg::DATA_WIDTH-1:0]   req_element_value,
   output logic                                    rsp_valid,
   output logic signed [imm_pkg::DATA_WIDTH-1:0]   rsp_product_value,
   output logic [imm_pkg::INDEX_WIDTH-1:0]         rsp_out_row,
   output logic [imm_pkg::INDEX_WIDTH-1:0]         rsp_out_col,
   input  logic                                    csr_wr_en,
   input  logic [imm_pkg::SIZE_WIDTH-1:0]          csr_wr_data
);

   // Index width per dimension; an entry lives at {row, col}.
   localparam int DimWidth  = $clog2(MAX_DIM);
   localparam int AddrWidth = 2 * DimWidth;
   // Wide enough for both the size register and MAX_DIM itself.
   localparam int SizeWidth = ($clog2(MAX_DIM + 1) > imm_pkg::SIZE_WIDTH) ?
                              $clog2(MAX_DIM + 1) : imm_pkg::SIZE_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [imm_pkg::SIZE_WIDTH-1:0]     csr_size_ff;
   logic [DimWidth-1:0]                k_ff, k_in;
   logic [DimWidth-1:0]                last_k_ff, last_k_in;
   logic [imm_pkg::INDEX_WIDTH-1:0]    row_ff, row_in;
   logic [imm_pkg::INDEX_WIDTH-1:0]    col_ff, col_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [imm_pkg::DATA_WIDTH-1:0]     rsp_value_ff, rsp_value_in;
   logic [imm_pkg::INDEX_WIDTH-1:0]    rsp_row_ff, rsp_row_in;
   logic [imm_pkg::INDEX_WIDTH-1:0]    rsp_col_ff, rsp_col_in;

   logic [SizeWidth-1:0]               size_ext;
   logic [SizeWidth-1:0]               size_used;
   logic                               in_range;
   logic                               wr_a, wr_b;
   logic [AddrWidth-1:0]               wr_addr;
   logic [AddrWidth-1:0]               a_rd_addr, b_rd_addr;
   logic [imm_pkg::DATA_WIDTH-1:0]     a_data, b_data;
   imm_pkg::tag_type                   issue_tag;
   logic                               mac_done;
   logic [imm_pkg::DATA_WIDTH-1:0]     mac_sum;

   // Saturate the size register at MAX_DIM.
   assign size_ext  = SizeWidth'(csr_size_ff);
   assign size_used = (size_ext < SizeWidth'(MAX_DIM)) ? size_ext : SizeWidth'(MAX_DIM);
   assign in_range  = (SizeWidth'(req_row) < size_used) && (SizeWidth'(req_col) < size_used);

   // Inside the size, row and col fit in DimWidth bits.
   assign wr_addr   = {DimWidth'(req_row), DimWidth'(req_col)};
   // Row of A walks across k; column of B walks down k.
   assign a_rd_addr = {DimWidth'(row_ff), k_ff};
   assign b_rd_addr = {k_ff, DimWidth'(col_ff)};

   // Writes happen only while idle and reads only while busy, so the RAMs
   // never see a read and a write of the same entry in flight together.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      last_k_in    = last_k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      issue_tag    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (imm_pkg::op_type'(req_op))
                  imm_pkg::OP_WRITE_A: begin
                     wr_a = in_range;
                  end
                  imm_pkg::OP_WRITE_B: begin
                     wr_b = in_range;
                  end
                  imm_pkg::OP_READ: begin
                     row_in = req_row;
                     col_in = req_col;
                     if (in_range) begin
                        // Start the walk over k = 0 .. n-1.
                        state_in  = ST_ISSUE;
                        k_in      = '0;
                        last_k_in = DimWidth'(size_used - SizeWidth'(1));
                     end else begin
                        // Outside the size: answer zero at once.
                        rsp_valid_in = 1'b1;
                        rsp_value_in = '0;
                        rsp_row_in   = req_row;
                        rsp_col_in   = req_col;
                     end
                  end
                  default: begin
                     // Unused op code: drop the word.
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            // Issue one product term per cycle to both RAMs.
            issue_tag.valid = 1'b1;
            issue_tag.first = (k_ff == '0);
            issue_tag.last  = (k_ff == last_k_ff);
            k_in            = DimWidth'(k_ff + 1'b1);
            if (k_ff == last_k_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Hold until the last term has been accumulated.
            if (mac_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = mac_sum;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         csr_size_ff  <= imm_pkg::SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_k_ff    <= last_k_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   imm_ram #(
      .AddrWidth (AddrWidth),
      .DataWidth (imm_pkg::DATA_WIDTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (issue_tag.valid),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   imm_ram #(
      .AddrWidth (AddrWidth),
      .DataWidth (imm_pkg::DATA_WIDTH)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (issue_tag.valid),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   imm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .a_data    (a_data),
      .b_data    (b_data),
      .done      (mac_done),
      .sum       (mac_sum)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;

endmodule

// ===== sv/imm_checker.sv =====
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the matrix multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module imm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [imm_pkg::OP_WIDTH-1:0]  req_op,
   input logic                          rsp_valid
);

   // A write word never produces a result strobe.
   write_no_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == imm_pkg::OP_WRITE_A || req_op == imm_pkg::OP_WRITE_B)
      |=> !rsp_valid)
      else $error("result strobe after a write word");

   // A read either starts the walk or answers at once, never both.
   read_walk_or_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == imm_pkg::OP_READ |=> (busy != rsp_valid))
      else $error("read word neither started nor answered");

   // Results appear only while idle.
   result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Finishing a walk always delivers its result.
   walk_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("walk ended without a result");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_valid (rsp_valid)
);

// ===== tb/integer_matrix_multiply_core_tb.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core_tb
// Self-checking bench for the integer matrix multiply core. Element writes
// and product reads go through the start/busy request port. A mirror of both
// matrices and of the size register predicts every product word, and a
// checker compares each strobed response with the oldest prediction. Directed
// cases cover extreme elements, reads outside the size, ignored writes, size
// zero and the unused op code. Random phases then sweep the size register.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM     = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 24;    // longer than one read of the largest size
   localparam int DRAIN_LIMIT = 4000;

   // Op code three has no meaning in the block; keep a name for it here.
   localparam logic [imm_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [imm_pkg::DATA_WIDTH-1:0]  product_value;
      logic [imm_pkg::INDEX_WIDTH-1:0] row;
      logic [imm_pkg::INDEX_WIDTH-1:0] col;
   } product_word_type;

   logic                                   clock = 1'b0;
   logic                                   reset;
   logic                                   start;
   logic                                   busy;
   logic [imm_pkg::OP_WIDTH-1:0]           req_op;
   logic [imm_pkg::INDEX_WIDTH-1:0]        req_row;
   logic [imm_pkg::INDEX_WIDTH-1:0]        req_col;
   logic signed [imm_pkg::DATA_WIDTH-1:0]  req_element_value;
   logic                                   rsp_valid;
   logic signed [imm_pkg::DATA_WIDTH-1:0]  rsp_product_value;
   logic [imm_pkg::INDEX_WIDTH-1:0]        rsp_out_row;
   logic [imm_pkg::INDEX_WIDTH-1:0]        rsp_out_col;
   logic                                   csr_wr_en;
   logic [imm_pkg::SIZE_WIDTH-1:0]         csr_wr_data;

   // Mirror of the block: both matrices, which entries hold data, and the size.
   logic [imm_pkg::DATA_WIDTH-1:0] left_mirror  [MAX_DIM*MAX_DIM];
   logic [imm_pkg::DATA_WIDTH-1:0] right_mirror [MAX_DIM*MAX_DIM];
   bit                             left_loaded  [MAX_DIM*MAX_DIM];
   bit                             right_loaded [MAX_DIM*MAX_DIM];
   logic [imm_pkg::SIZE_WIDTH-1:0] size_mirror;

   product_word_type pending_products[$];

   int fail_count;
   int cycle_count;
   int burst_left;
   int phase_words;   // words accepted in the current phase

   integer_matrix_multiply_core #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop: no correct run comes near this many cycles.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   // Size in use: anything above the matrix dimension saturates.
   function automatic int active_size();
      return (int'(size_mirror) > MAX_DIM) ? MAX_DIM : int'(size_mirror);
   endfunction

   function automatic bit within_size(input logic [imm_pkg::INDEX_WIDTH-1:0] r,
                                      input logic [imm_pkg::INDEX_WIDTH-1:0] c);
      return (int'(r) < active_size()) && (int'(c) < active_size());
   endfunction

   // Dot product of row r of A and column c of B, wrapped to 32 bits.
   function automatic logic [imm_pkg::DATA_WIDTH-1:0] dot_product_element(
         input logic [imm_pkg::INDEX_WIDTH-1:0] r,
         input logic [imm_pkg::INDEX_WIDTH-1:0] c);
      logic [imm_pkg::DATA_WIDTH-1:0] acc;
      acc = '0;
      for (int k = 0; k < active_size(); k++)
         acc = acc + left_mirror[int'(r)*MAX_DIM + k] * right_mirror[k*MAX_DIM + int'(c)];
      return acc;
   endfunction

   // Apply one accepted word to the mirror; a read queues its product word.
   function automatic void record_accepted_word(
         input logic [imm_pkg::OP_WIDTH-1:0]    op,
         input logic [imm_pkg::INDEX_WIDTH-1:0] r,
         input logic [imm_pkg::INDEX_WIDTH-1:0] c,
         input logic [imm_pkg::DATA_WIDTH-1:0]  v);
      product_word_type word;
      int               addr;
      addr = int'(r)*MAX_DIM + int'(c);
      phase_words++;
      unique case (op)
         imm_pkg::OP_WRITE_A: begin
            if (within_size(r, c)) begin
               left_mirror[addr] = v;
               left_loaded[addr] = 1'b1;
            end
         end
         imm_pkg::OP_WRITE_B: begin
            if (within_size(r, c)) begin
               right_mirror[addr] = v;
               right_loaded[addr] = 1'b1;
            end
         end
         imm_pkg::OP_READ: begin
            word.product_value = within_size(r, c) ? dot_product_element(r, c) : '0;
            word.row           = r;
            word.col           = c;
            pending_products.push_back(word);
         end
         default: ;   // unused code: dropped by the block
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Response checker: every strobe must match the oldest pending product.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      product_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_products.size() == 0) begin
            $error("product word with none pending: row %0d col %0d value %0d",
                   rsp_out_row, rsp_out_col, rsp_product_value);
            fail_count++;
         end else begin
            want = pending_products.pop_front();
            if (rsp_product_value !== want.product_value) begin
               $error("product_value: expected %0d, actual %0d",
                      $signed(want.product_value), rsp_product_value);
               fail_count++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, actual %0d", want.row, rsp_out_row);
               fail_count++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, actual %0d", want.col, rsp_out_col);
               fail_count++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------

   // Send one request word. Enter and leave at a falling edge; start stays
   // high on return so that a following word with no gap goes out back to back.
   task automatic send_word(input logic [imm_pkg::OP_WIDTH-1:0]    op,
                            input logic [imm_pkg::INDEX_WIDTH-1:0] r,
                            input logic [imm_pkg::INDEX_WIDTH-1:0] c,
                            input logic [imm_pkg::DATA_WIDTH-1:0]  v);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_op            <= op;
      req_row           <= r;
      req_col           <= c;
      req_element_value <= v;
      // Hold the word until an edge sees busy low.
      do @(posedge clock); while (busy);
      record_accepted_word(op, r, c, v);
      @(negedge clock);
   endtask

   // Drop start and hold until every pending product has come back.
   task automatic drain_pending_products();
      start <= 1'b0;
      @(negedge clock);
      while (pending_products.size() != 0) @(negedge clock);
   endtask

   // Write the size register with the block idle.
   task automatic write_matrix_size(input logic [imm_pkg::SIZE_WIDTH-1:0] value);
      drain_pending_products();
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= imm_pkg::SIZE_WIDTH'($urandom);
      size_mirror = value;
   endtask

   function automatic logic [imm_pkg::DATA_WIDTH-1:0] draw_element();
      unique case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         4:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Mostly inside the size in use, now and then anywhere.
   function automatic logic [imm_pkg::INDEX_WIDTH-1:0] draw_index();
      if (active_size() > 0 && $urandom_range(0, 9) < 8)
         return imm_pkg::INDEX_WIDTH'($urandom_range(0, active_size() - 1));
      return imm_pkg::INDEX_WIDTH'($urandom_range(0, MAX_DIM - 1));
   endfunction

   // Load whatever row r of A and column c of B still lack, so the read is legal.
   task automatic load_missing_operands(input logic [imm_pkg::INDEX_WIDTH-1:0] r,
                                        input logic [imm_pkg::INDEX_WIDTH-1:0] c);
      for (int k = 0; k < active_size(); k++) begin
         if (!left_loaded[int'(r)*MAX_DIM + k])
            send_word(imm_pkg::OP_WRITE_A, r, imm_pkg::INDEX_WIDTH'(k), draw_element());
         if (!right_loaded[k*MAX_DIM + int'(c)])
            send_word(imm_pkg::OP_WRITE_B, imm_pkg::INDEX_WIDTH'(k), c, draw_element());
      end
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Size one: single products of the extreme elements.
   task automatic test_single_element_extremes();
      write_matrix_size(5'd1);
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
      send_word(imm_pkg::OP_WRITE_B, 4'd0, 4'd0, 32'hffff_ffff);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd0, $urandom);   // most negative times -1 wraps
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'h7fff_ffff);
      send_word(imm_pkg::OP_WRITE_B, 4'd0, 4'd0, 32'h7fff_ffff);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd0, $urandom);
   endtask

   // Size two: a two-term sum, then writes outside a smaller size must not land.
   task automatic test_ignored_writes_keep_data();
      write_matrix_size(5'd2);
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'h8000_0000);
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd1, 32'h7fff_ffff);
      send_word(imm_pkg::OP_WRITE_B, 4'd0, 4'd0, 32'h8000_0000);
      send_word(imm_pkg::OP_WRITE_B, 4'd1, 4'd0, 32'h7fff_ffff);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd0, 32'h0);
      write_matrix_size(5'd1);
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd1, 32'h1234_5678);
      send_word(imm_pkg::OP_WRITE_B, 4'd1, 4'd0, 32'h0000_0001);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd1, 32'hffff_ffff); // outside: zero, indices echoed
      send_word(imm_pkg::OP_READ, 4'd15, 4'd15, 32'h0);
      write_matrix_size(5'd2);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd0, $urandom);
   endtask

   // Size zero puts every index outside; op code three is dropped.
   task automatic test_empty_size_and_unused_op();
      write_matrix_size(5'd0);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd0, $urandom);
      send_word(imm_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'h5555_5555);
      send_word(OP_UNUSED, 4'd15, 4'd15, 32'hffff_ffff);
      send_word(imm_pkg::OP_READ, 4'd15, 4'd0, $urandom);
      send_word(OP_UNUSED, 4'd0, 4'd0, 32'h0);
      send_word(imm_pkg::OP_READ, 4'd0, 4'd15, $urandom);
   endtask

   // One random phase at a given size: mostly element loads and legal reads,
   // with writes outside the size and unused codes as noise.
   task automatic test_random_traffic(input logic [imm_pkg::SIZE_WIDTH-1:0] size_value,
                                      input int budget);
      logic [imm_pkg::OP_WIDTH-1:0]    op;
      logic [imm_pkg::INDEX_WIDTH-1:0] r;
      logic [imm_pkg::INDEX_WIDTH-1:0] c;
      int                              pick;
      write_matrix_size(size_value);
      phase_words = 0;
      while (phase_words < budget) begin
         pick = $urandom_range(0, 99);
         r    = draw_index();
         c    = draw_index();
         if (pick < 33)
            op = imm_pkg::OP_WRITE_A;
         else if (pick < 66)
            op = imm_pkg::OP_WRITE_B;
         else if (pick < 97)
            op = imm_pkg::OP_READ;
         else
            op = OP_UNUSED;
         if (op == imm_pkg::OP_READ && within_size(r, c))
            load_missing_operands(r, c);
         send_word(op, r, c, (op == imm_pkg::OP_READ) ? $urandom : draw_element());
         // Now and then hold off until every pending product is back.
         if ($urandom_range(0, 59) == 0)
            drain_pending_products();
      end
   endtask

   // Sweep the size: both ends, saturation above the dimension, and a few in between.
   task automatic test_size_sweep();
      logic [imm_pkg::SIZE_WIDTH-1:0] sizes[] = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd0, 5'd3,
                                                  5'd17, 5'd8, 5'd5, 5'd1, 5'd4, 5'd2};
      foreach (sizes[i])
         test_random_traffic(sizes[i], 85);
      test_random_traffic(imm_pkg::SIZE_WIDTH'($urandom_range(0, 31)), 80);
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------
   initial begin
      int waited;
      // Drive every input to a known value before the first edge.
      reset             = 1'b1;
      start             = 1'b0;
      req_op            = imm_pkg::OP_WRITE_A;
      req_row           = '0;
      req_col           = '0;
      req_element_value = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      fail_count        = 0;
      cycle_count       = 0;
      burst_left        = 0;
      phase_words       = 0;
      size_mirror       = imm_pkg::SIZE_RESET;
      foreach (left_loaded[i]) begin
         left_loaded[i]  = 1'b0;
         right_loaded[i] = 1'b0;
         left_mirror[i]  = '0;
         right_mirror[i] = '0;
      end
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_element_extremes();
      test_ignored_writes_keep_data();
      test_empty_size_and_unused_op();
      test_size_sweep();

      // Wind down: drop start, collect what is still pending, then settle.
      start <= 1'b0;
      waited = 0;
      while (pending_products.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_products.size() != 0) begin
         $error("%0d product words never arrived", pending_products.size());
         fail_count++;
      end
      repeat (SETTLE) @(negedge clock);

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== integer_matrix_multiply_core.f =====
sv/imm_pkg.sv
sv/imm_ram.sv
sv/imm_mac.sv
sv/integer_matrix_multiply_core.sv
sv/imm_checker.sv
tb/integer_matrix_multiply_core_tb.sv
